@@ rtl/cpf_pkg.sv @@
// ----------------------------------------------------------------------------
// cpf_pkg
// Codes, entry layout and mode transition function for the CAN PDU mode
// and receive filter core.
// ----------------------------------------------------------------------------
package cpf_pkg;

	localparam int ID_W = 29;

	// func codes
	localparam logic [1:0] F_MODE  = 2'd0;
	localparam logic [1:0] F_FRAME = 2'd1;
	localparam logic [1:0] F_LOAD  = 2'd2;

	// PDU modes
	localparam logic [2:0] M_OFF       = 3'd0;
	localparam logic [2:0] M_RX        = 3'd1;
	localparam logic [2:0] M_TX        = 3'd2;
	localparam logic [2:0] M_ONLINE    = 3'd3;
	localparam logic [2:0] M_OFFACT    = 3'd4;
	localparam logic [2:0] M_OFFACT_RX = 3'd5;

	// mode requests
	localparam logic [2:0] R_OFFLINE    = 3'd0;
	localparam logic [2:0] R_RX_OFF     = 3'd1;
	localparam logic [2:0] R_RX_ON      = 3'd2;
	localparam logic [2:0] R_TX_OFF     = 3'd3;
	localparam logic [2:0] R_TX_ON      = 3'd4;
	localparam logic [2:0] R_ONLINE     = 3'd5;
	localparam logic [2:0] R_TX_OFF_ACT = 3'd6;

	// result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_CHAN = 3'd1;
	localparam logic [2:0] ST_DROP     = 3'd2;
	localparam logic [2:0] ST_NO_MATCH = 3'd3;
	localparam logic [2:0] ST_LEN      = 3'd4;

	typedef struct packed {
		logic [3:0]      chan;
		logic [ID_W-1:0] low;
		logic [ID_W-1:0] high;
		logic [3:0]      len;
	} filt_entry_t;

	// bit 0 of the mode is the rx flag, bits 2:1 pick off/tx/off-active (online is tx with rx)
	function automatic logic [2:0] next_mode(input logic [2:0] req, input logic [2:0] old);
		logic [2:0] m;
		m = (old > M_OFFACT_RX) ? M_OFF : old;
		case (req)
			R_OFFLINE:    next_mode = M_OFF;
			R_RX_OFF:     next_mode = m & 3'b110;
			R_RX_ON:      next_mode = m | 3'b001;
			R_TX_OFF:     next_mode = {2'b00, m[0]};
			R_TX_ON:      next_mode = {2'b01, m[0]};
			R_ONLINE:     next_mode = M_ONLINE;
			R_TX_OFF_ACT: next_mode = {2'b10, m[0]};
			default:      next_mode = m;
		endcase
	endfunction

endpackage

@@ rtl/cpf_ram.sv @@
// ----------------------------------------------------------------------------
// cpf_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpf_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic                              re,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/can_pdu_mode_and_rx_filter_core.sv @@
// ----------------------------------------------------------------------------
// can_pdu_mode_and_rx_filter_core
// Per-channel PDU mode keeper and first-match receive filter walk.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------------------------
//   command  | start / busy     | func channel mode_request can_id dlc
//            |                  | entry_index entry_low entry_high
//   result   | done (1 cycle)   | status pdu_mode delivered hit_index
//            |                  | frame_id frame_len
//   config   | cfg_we           | cfg_data (entry_count)
//
// One command at a time. Mode requests, loads and frames that stop at the
// mode check pass S_RD and S_MODE and then give a registered done; a filter
// walk reads one entry per cycle from the filter RAM up to the first hit or
// the last entry. Reset clears every channel to offline (per-channel valid
// bits, no clearing pass). The result receiver cannot stall; busy is high
// until the result beat.
// ----------------------------------------------------------------------------
module can_pdu_mode_and_rx_filter_core
	import cpf_pkg::*;
#(
	parameter int CHANNELS = 4,
	parameter int ENTRIES  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [1:0]      func,
	input  logic [3:0]      channel,
	input  logic [2:0]      mode_request,
	input  logic [ID_W-1:0] can_id,
	input  logic [3:0]      dlc,
	input  logic [3:0]      entry_index,
	input  logic [ID_W-1:0] entry_low,
	input  logic [ID_W-1:0] entry_high,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_data,
	output logic            done,
	output logic [2:0]      status,
	output logic [2:0]      pdu_mode,
	output logic            delivered,
	output logic [3:0]      hit_index,
	output logic [ID_W-1:0] frame_id,
	output logic [3:0]      frame_len
);

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = $clog2(ENTRIES + 1);
	localparam logic [PW-1:0] N_MAX = PW'(ENTRIES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_MODE = 2'd2;
	localparam logic [1:0] S_WALK = 2'd3;

	logic [1:0]          state_q;
	logic [CHANNELS-1:0] valid_q;
	logic [4:0]          ec_q;

	logic [1:0]      func_q;
	logic [3:0]      chan_q;
	logic [2:0]      req_q;
	logic [ID_W-1:0] cid_q;
	logic [3:0]      dlc_q;
	logic [3:0]      eidx_q;
	logic [ID_W-1:0] elo_q;
	logic [ID_W-1:0] ehi_q;

	logic [PW-1:0] n_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] idx_s1;
	logic          pend_s1;
	logic [2:0]    mode_q;

	logic            done_q;
	logic [2:0]      status_q;
	logic [2:0]      pdu_mode_q;
	logic            delivered_q;
	logic [3:0]      hit_index_q;
	logic [ID_W-1:0] frame_id_q;
	logic [3:0]      frame_len_q;

	logic        accept;
	logic        chan_ok;
	logic        eidx_ok;
	logic        m_we;
	logic        m_re;
	logic [2:0]  m_rdata;
	logic [2:0]  old_mode;
	logic [2:0]  new_mode;
	logic        rx_on;
	logic [PW-1:0] n_lim;

	logic        f_we;
	logic        f_re;
	filt_entry_t f_wdata;
	filt_entry_t f_rdata;
	logic        hit;
	logic        last;

	logic            fin;
	logic            start_walk;
	logic [2:0]      r_status;
	logic [2:0]      r_mode;
	logic            r_deliv;
	logic [3:0]      r_hit;
	logic [ID_W-1:0] r_fid;
	logic [3:0]      r_flen;

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign chan_ok = ({1'b0, chan_q} < 5'(CHANNELS));
	assign eidx_ok = ({1'b0, eidx_q} < 5'(ENTRIES));

	// mode memory: read in S_RD, data and write-back in S_MODE
	assign m_re     = (state_q == S_RD);
	assign m_we     = (state_q == S_MODE) && (func_q == F_MODE) && chan_ok;
	assign old_mode = (valid_q[chan_q[CW-1:0]] && (m_rdata <= M_OFFACT_RX)) ? m_rdata : M_OFF;
	assign new_mode = next_mode(req_q, old_mode);
	assign rx_on    = (old_mode == M_RX) || (old_mode == M_ONLINE) || (old_mode == M_OFFACT_RX);
	assign n_lim    = (ec_q > 5'(ENTRIES)) ? N_MAX : ec_q[PW-1:0];

	cpf_ram #(
		.W(3),
		.D(CHANNELS)
	) u_mode_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(chan_q[CW-1:0]),
		.wdata(new_mode),
		.re   (m_re),
		.raddr(chan_q[CW-1:0]),
		.rdata(m_rdata)
	);

	// filter memory
	assign f_we    = (state_q == S_MODE) && (func_q == F_LOAD) && eidx_ok;
	assign f_wdata = '{chan: chan_q, low: elo_q, high: ehi_q, len: dlc_q};
	assign f_re    = (state_q == S_WALK) && (ptr_q < n_q);

	cpf_ram #(
		.W($bits(filt_entry_t)),
		.D(ENTRIES)
	) u_filt_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(eidx_q[IW-1:0]),
		.wdata(f_wdata),
		.re   (f_re),
		.raddr(ptr_q[IW-1:0]),
		.rdata(f_rdata)
	);

	assign hit  = pend_s1 && (f_rdata.chan == chan_q) && (f_rdata.low <= cid_q) &&
		(f_rdata.high >= cid_q);
	assign last = ((idx_s1 + PW'(1)) == n_q);

	always_comb begin
		fin        = 1'b0;
		start_walk = 1'b0;
		r_status   = ST_OK;
		r_mode     = M_OFF;
		r_deliv    = 1'b0;
		r_hit      = 4'd0;
		r_fid      = '0;
		r_flen     = 4'd0;
		if (state_q == S_MODE) begin
			case (func_q)
				F_MODE: begin
					fin = 1'b1;
					if (!chan_ok) begin
						r_status = ST_BAD_CHAN;
					end else begin
						r_mode = new_mode;
					end
				end
				F_FRAME: begin
					if (!chan_ok) begin
						fin      = 1'b1;
						r_status = ST_BAD_CHAN;
					end else if (!rx_on) begin
						fin      = 1'b1;
						r_status = ST_DROP;
						r_mode   = old_mode;
					end else if (n_lim == '0) begin
						fin      = 1'b1;
						r_status = ST_NO_MATCH;
						r_mode   = old_mode;
					end else begin
						start_walk = 1'b1;
					end
				end
				F_LOAD: begin
					fin    = 1'b1;
					r_mode = chan_ok ? old_mode : M_OFF;
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end else if ((state_q == S_WALK) && pend_s1) begin
			r_mode = mode_q;
			if (hit) begin
				fin   = 1'b1;
				r_hit = 4'(idx_s1);
				if (f_rdata.len != dlc_q) begin
					r_status = ST_LEN;
				end else begin
					r_deliv = 1'b1;
					r_fid   = cid_q;
					r_flen  = dlc_q;
				end
			end else if (last) begin
				fin      = 1'b1;
				r_status = ST_NO_MATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			ec_q    <= 5'd0;
			pend_s1 <= 1'b0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= fin;
			if (cfg_we) begin
				ec_q <= cfg_data;
			end
			if (m_we) begin
				valid_q[chan_q[CW-1:0]] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MODE;
				end
				S_MODE: begin
					ptr_q   <= '0;
					pend_s1 <= 1'b0;
					state_q <= start_walk ? S_WALK : S_IDLE;
				end
				S_WALK: begin
					if (f_re) begin
						ptr_q <= ptr_q + PW'(1);
					end
					pend_s1 <= f_re && !fin;
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			chan_q <= channel;
			req_q  <= mode_request;
			cid_q  <= can_id;
			dlc_q  <= dlc;
			eidx_q <= entry_index;
			elo_q  <= entry_low;
			ehi_q  <= entry_high;
		end
		if (state_q == S_MODE) begin
			n_q    <= n_lim;
			mode_q <= old_mode;
		end
		idx_s1 <= ptr_q;
		if (fin) begin
			status_q    <= r_status;
			pdu_mode_q  <= r_mode;
			delivered_q <= r_deliv;
			hit_index_q <= r_hit;
			frame_id_q  <= r_fid;
			frame_len_q <= r_flen;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign pdu_mode  = pdu_mode_q;
	assign delivered = delivered_q;
	assign hit_index = hit_index_q;
	assign frame_id  = frame_id_q;
	assign frame_len = frame_len_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_deliv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && delivered) |-> (status == ST_OK))
		else $error("delivered frame with non-ok status");

	a_drop_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_DROP)) |->
		((pdu_mode == M_OFF) || (pdu_mode == M_TX) || (pdu_mode == M_OFFACT)))
		else $error("frame dropped while channel was receive-online");
`endif

endmodule
